@@ rtl/core/lpb_pkg.sv @@
// ----------------------------------------------------------------------------
// lpb_pkg: shared types and constants for the prime search core
// Value width, derived widths, sequencer states and remainder unit bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lpb_pkg;

    // width of bound and result values
    localparam int VALUE_BITS = 31;
    // square of the divisor may pass the candidate by one step
    localparam int SQ_BITS    = VALUE_BITS + 1;
    // bit counter for the remainder unit
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    // smallest prime and first trial divisor, smallest bound that is searched, and that divisor's square
    localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);
    localparam logic [VALUE_BITS-1:0] MIN_BOUND   = VALUE_BITS'(3);
    localparam logic [SQ_BITS-1:0]    FIRST_SQ    = SQ_BITS'(4);

    typedef logic [VALUE_BITS-1:0] value_t;

    // search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_TEST,
        ST_DIV,
        ST_OUT
    } state_t;

    // request to the remainder unit
    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } rem_req_t;

    // status from the remainder unit
    typedef struct packed {
        logic done;
        logic is_zero;
    } rem_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/lpb_rem.sv @@
// ----------------------------------------------------------------------------
// lpb_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_rem (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire lpb_pkg::rem_req_t req,
    output lpb_pkg::rem_rsp_t rsp
);
    import lpb_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    value_t              r_reg, r_next;
    value_t              q_reg, q_next;
    value_t              d_reg, d_next;

    logic [VALUE_BITS:0] trial;
    logic [VALUE_BITS:0] diff;
    logic                ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_reg, q_reg[VALUE_BITS-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(VALUE_BITS - 1);
            r_next    = '0;
            q_next    = req.dividend;
            d_next    = req.divisor;
        end else if (busy_reg) begin
            r_next = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            q_next = {q_reg[VALUE_BITS-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.is_zero = (r_reg == '0);

    // partial remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (r_reg < d_reg))
        else $error("partial remainder not reduced");

    // done is a single pulse that ends a busy run
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("done without a finished division");

    // a division runs its full length once started
    a_busy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg != '0) |=> busy_reg)
        else $error("division ended early");

endmodule

`default_nettype wire

@@ rtl/core/largest_primes_below_bound_core.sv @@
// ----------------------------------------------------------------------------
// largest_primes_below_bound_core: largest two primes below a bound
// Scans candidates downward from bound-1 and tests each by trial division,
// sharing one bit-serial remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: each trial divisor takes a test step and a remainder unit run,
//   each candidate a candidate step, and each bound an accept step in idle
//   and a deliver step in the output state.
// Throughput: one bound at a time; s_ready is high only while the sequencer
//   is idle. A finished result waits in the output register meanwhile.
// Reset: aresetn is synchronous, active low; clears sequencer and output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_primes_below_bound_core (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  lpb_pkg::value_t  s_bound,
    output logic                   m_valid,
    input  wire                    m_ready,
    output lpb_pkg::value_t        m_largest_prime,
    output lpb_pkg::value_t        m_second_prime
);
    import lpb_pkg::*;

    state_t              state_reg, state_next;
    value_t              cand_reg, cand_next;
    value_t              d_reg, d_next;
    logic [SQ_BITS-1:0]  sq_reg, sq_next;
    value_t              first_reg, first_next;
    value_t              second_reg, second_next;
    logic                m_valid_reg, m_valid_next;
    value_t              m_largest_reg, m_largest_next;
    value_t              m_second_reg, m_second_next;

    rem_req_t            rem_req;
    rem_rsp_t            rem_rsp;

    // shared remainder unit
    lpb_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    // search sequencer
    always_comb begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        m_valid_next   = m_valid_reg;
        m_largest_next = m_largest_reg;
        m_second_next  = m_second_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = cand_reg;
        rem_req.divisor  = d_reg;

        // output beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    first_next  = '0;
                    second_next = '0;
                    cand_next   = s_bound - 1'b1;
                    state_next  = (s_bound >= MIN_BOUND) ? ST_CAND : ST_OUT;
                end
            end
            ST_CAND: begin
                d_next  = FIRST_PRIME;
                sq_next = FIRST_SQ;
                state_next = (cand_reg < FIRST_PRIME) ? ST_OUT : ST_TEST;
            end
            ST_TEST: begin
                if (sq_reg > {1'b0, cand_reg}) begin
                    // no divisor up to the square root: prime
                    if (first_reg == '0) begin
                        first_next = cand_reg;
                        cand_next  = cand_reg - 1'b1;
                        state_next = ST_CAND;
                    end else begin
                        second_next = cand_reg;
                        state_next  = ST_OUT;
                    end
                end else begin
                    rem_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.is_zero) begin
                        cand_next  = cand_reg - 1'b1;
                        state_next = ST_CAND;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        d_next     = d_reg + 1'b1;
                        state_next = ST_TEST;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_largest_next = first_reg;
                    m_second_next  = second_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cand_reg      <= cand_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        m_largest_reg <= m_largest_next;
        m_second_reg  <= m_second_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_largest_prime = m_largest_reg;
    assign m_second_prime  = m_second_reg;

    // a division is only started while the divisor square fits the candidate
    a_div_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (sq_reg <= {1'b0, cand_reg} && d_reg >= FIRST_PRIME))
        else $error("trial divisor out of range");

    // a nonzero second prime is always below the first
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_second_reg != '0) |-> (m_largest_reg > m_second_reg))
        else $error("result primes out of order");

    // a pending result beat is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_largest_reg) && $stable(m_second_reg))
        else $error("pending result overwritten");

    // the squared divisor tracks the divisor
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST) |-> (sq_reg == SQ_BITS'(d_reg) * SQ_BITS'(d_reg)))
        else $error("divisor square out of step");

endmodule

`default_nettype wire
